@@ hw/rtl/ci2r_pkg.sv @@
package ci2r_pkg;

   // Field widths
   localparam int KIND_W = 3;
   localparam int OBJ_W  = 16;
   localparam int ERR_W  = 2;
   localparam int PRIO_W = 7;

   // Default operator stack depth
   localparam int STACK_DEPTH_DEF = 32;

   // Token and stack entry kinds
   localparam logic [KIND_W-1:0] KIND_OBJ   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_UNION = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PLUS  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_MINUS = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LPAR  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_RPAR  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNIV  = 3'd6;

   // Result kind for the universe object
   localparam logic [KIND_W-1:0] OUT_UNIV = 3'd4;

   // Error codes
   localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
   localparam logic [ERR_W-1:0] ERR_RPAR = 2'd1;
   localparam logic [ERR_W-1:0] ERR_LPAR = 2'd2;
   localparam logic [ERR_W-1:0] ERR_OVF  = 2'd3;

   // Classified token passed from front to back
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [OBJ_W-1:0]  id;
      logic              last;
      logic              known;
      logic [PRIO_W-1:0] ip;
   } tok_type;

   // Stack command from the sequencer
   typedef struct packed {
      logic              push;
      logic              pop;
      logic              clear;
      logic [KIND_W-1:0] kind;
      logic [OBJ_W-1:0]  obj;
   } stk_cmd_type;

   // Stack status toward the sequencer
   typedef struct packed {
      logic              full;
      logic              empty;
      logic [KIND_W-1:0] top_kind;
      logic [OBJ_W-1:0]  top_obj;
   } stk_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_POP,
      ST_FLUSH,
      ST_ERR,
      ST_FIN
   } state_type;

   // Input priority of a token
   function automatic logic [PRIO_W-1:0] prio_in(input logic [KIND_W-1:0] kind);
      logic [PRIO_W-1:0] p;
      case (kind)
         KIND_LPAR:  p = 7'd99;
         KIND_UNION: p = 7'd1;
         KIND_PLUS:  p = 7'd3;
         KIND_MINUS: p = 7'd3;
         KIND_RPAR:  p = 7'd0;
         default:    p = 7'd101;
      endcase
      return p;
   endfunction

   // Priority of an entry sitting on the stack
   function automatic logic [PRIO_W-1:0] prio_stack(input logic [KIND_W-1:0] kind);
      logic [PRIO_W-1:0] p;
      case (kind)
         KIND_LPAR:  p = 7'd0;
         KIND_UNION: p = 7'd2;
         KIND_PLUS:  p = 7'd4;
         KIND_MINUS: p = 7'd4;
         default:    p = 7'd100;
      endcase
      return p;
   endfunction

   // Result kind for a popped stack entry
   function automatic logic [KIND_W-1:0] entry_out_kind(input logic [KIND_W-1:0] kind);
      logic [KIND_W-1:0] k;
      case (kind)
         KIND_UNIV: k = OUT_UNIV;
         default:   k = kind;
      endcase
      return k;
   endfunction

endpackage

@@ hw/rtl/ci2r_front.sv @@
module ci2r_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ci2r_pkg::KIND_W-1:0]     req_token_kind,
   input  logic [ci2r_pkg::OBJ_W-1:0]      req_object_id,
   input  logic                            req_last_token,
   output logic                            q_valid,
   input  logic                            q_ready,
   output ci2r_pkg::tok_type               q_tok
);
   import ci2r_pkg::*;

   tok_type    fifo_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   tok_type    tok_new;
   logic       do_push, do_pop;

   // Classify the incoming token
   always_comb begin
      tok_new.kind  = req_token_kind;
      tok_new.id    = (req_token_kind == KIND_OBJ) ? req_object_id : '0;
      tok_new.last  = req_last_token;
      tok_new.known = (req_token_kind <= KIND_RPAR);
      tok_new.ip    = prio_in(req_token_kind);
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_tok     = fifo_ff[rd_ptr_ff];
   assign do_push   = req_valid && req_ready;
   assign do_pop    = q_valid && q_ready;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the classified token
   always_ff @(posedge clock) begin
      if (do_push) begin
         fifo_ff[wr_ptr_ff] <= tok_new;
      end
   end

endmodule

@@ hw/rtl/ci2r_stack.sv @@
module ci2r_stack #(
   parameter int DEPTH = ci2r_pkg::STACK_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ci2r_pkg::stk_cmd_type  cmd,
   output ci2r_pkg::stk_stat_type stat
);
   import ci2r_pkg::*;

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);

   logic [KIND_W-1:0] kind_mem [DEPTH];
   logic [OBJ_W-1:0]  obj_mem  [DEPTH];

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  top_idx;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [KIND_W-1:0] top_kind_ff;
   logic [OBJ_W-1:0]  top_obj_ff;

   // Next fill count
   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Read the entry that will be on top next cycle
   assign top_idx = count_in - CNT_W'(1);
   assign rd_addr = top_idx[ADDR_W-1:0];
   assign wr_addr = count_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Write on push; a push makes the new entry the top, so forward it
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         kind_mem[wr_addr] <= cmd.kind;
         obj_mem[wr_addr]  <= cmd.obj;
         top_kind_ff       <= cmd.kind;
         top_obj_ff        <= cmd.obj;
      end else begin
         top_kind_ff <= kind_mem[rd_addr];
         top_obj_ff  <= obj_mem[rd_addr];
      end
   end

   always_comb begin
      stat.full     = (count_ff == CNT_W'(DEPTH));
      stat.empty    = (count_ff == '0);
      stat.top_kind = top_kind_ff;
      stat.top_obj  = top_obj_ff;
   end

endmodule

@@ hw/rtl/ci2r_back.sv @@
module ci2r_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   output logic                           q_ready,
   input  ci2r_pkg::tok_type              q_tok,
   output ci2r_pkg::stk_cmd_type          cmd,
   input  ci2r_pkg::stk_stat_type         stat,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ci2r_pkg::KIND_W-1:0]    rsp_out_kind,
   output logic [ci2r_pkg::OBJ_W-1:0]     rsp_out_object_id,
   output logic [ci2r_pkg::ERR_W-1:0]     rsp_error_code,
   output logic                           rsp_run_last,
   output logic                           rsp_expr_done
);
   import ci2r_pkg::*;

   state_type         state_ff, state_in;
   tok_type           cur_ff, cur_in;
   logic              aps_ff, aps_in;
   logic [ERR_W-1:0]  err_ff, err_in;

   // Pending result: held back until it is known whether it ends the step
   logic              pend_valid_ff, pend_valid_in;
   logic [KIND_W-1:0] pend_kind_ff, pend_kind_in;
   logic [OBJ_W-1:0]  pend_id_ff, pend_id_in;
   logic [ERR_W-1:0]  pend_err_ff, pend_err_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [OBJ_W-1:0]  rsp_id_ff, rsp_id_in;
   logic [ERR_W-1:0]  rsp_err_ff, rsp_err_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_done_ff, rsp_done_in;

   logic              out_free, emit_ok, pop_hit, skip_tok;
   logic              emit, fin_move;
   logic [KIND_W-1:0] emit_kind;
   logic [OBJ_W-1:0]  emit_id;
   logic [ERR_W-1:0]  emit_err;
   state_type         end_state;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_ok   = !pend_valid_ff || out_free;
   assign pop_hit   = !stat.empty && (cur_ff.ip < prio_stack(stat.top_kind));
   assign skip_tok  = !cur_ff.known ||
                      (aps_ff && (cur_ff.kind == KIND_UNION || cur_ff.kind == KIND_PLUS));
   assign end_state = cur_ff.last ? ST_FLUSH : ST_FIN;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) state_in = ST_START;
         end
         ST_START: begin
            if (skip_tok) begin
               state_in = end_state;
            end else if (aps_ff && cur_ff.kind == KIND_MINUS && stat.full) begin
               state_in = ST_ERR;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (pop_hit) begin
               state_in = ST_POP;
            end else if (cur_ff.kind == KIND_RPAR) begin
               state_in = stat.empty ? ST_ERR : end_state;
            end else begin
               state_in = stat.full ? ST_ERR : end_state;
            end
         end
         ST_FLUSH: begin
            if (stat.empty) begin
               state_in = ST_FIN;
            end else if (stat.top_kind == KIND_LPAR) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            if (emit_ok) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!pend_valid_ff || out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Stack commands, result emission and token bookkeeping
   always_comb begin
      q_ready   = 1'b0;
      cmd       = '0;
      emit      = 1'b0;
      emit_kind = entry_out_kind(stat.top_kind);
      emit_id   = stat.top_obj;
      emit_err  = ERR_NONE;
      fin_move  = 1'b0;
      cur_in    = cur_ff;
      aps_in    = aps_ff;
      err_in    = err_ff;
      case (state_ff)
         ST_IDLE: begin
            q_ready = 1'b1;
            cur_in  = q_tok;
            err_in  = ERR_NONE;
         end
         ST_START: begin
            if (skip_tok) begin
               if (cur_ff.known) aps_in = (cur_ff.kind == KIND_UNION);
            end else begin
               aps_in = (cur_ff.kind == KIND_LPAR || cur_ff.kind == KIND_UNION);
               if (aps_ff && cur_ff.kind == KIND_MINUS) begin
                  if (stat.full) begin
                     err_in = ERR_OVF;
                  end else begin
                     cmd.push = 1'b1;
                     cmd.kind = KIND_UNIV;
                     cmd.obj  = '0;
                  end
               end
            end
         end
         ST_POP: begin
            if (pop_hit) begin
               // drop a popped '(' silently
               if (stat.top_kind != KIND_LPAR) begin
                  if (emit_ok) begin
                     emit    = 1'b1;
                     cmd.pop = 1'b1;
                  end
               end else begin
                  cmd.pop = 1'b1;
               end
            end else if (cur_ff.kind == KIND_RPAR) begin
               if (stat.empty) begin
                  err_in = ERR_RPAR;
               end else begin
                  cmd.pop = 1'b1;
               end
            end else if (stat.full) begin
               err_in = ERR_OVF;
            end else begin
               cmd.push = 1'b1;
               cmd.kind = cur_ff.kind;
               cmd.obj  = cur_ff.id;
            end
         end
         ST_FLUSH: begin
            if (!stat.empty) begin
               if (stat.top_kind == KIND_LPAR) begin
                  err_in = ERR_LPAR;
               end else if (emit_ok) begin
                  emit    = 1'b1;
                  cmd.pop = 1'b1;
               end
            end
         end
         ST_ERR: begin
            if (emit_ok) begin
               emit      = 1'b1;
               emit_kind = KIND_OBJ;
               emit_id   = '0;
               emit_err  = err_ff;
               cmd.clear = 1'b1;
               aps_in    = 1'b1;
            end
         end
         ST_FIN: begin
            fin_move = pend_valid_ff && out_free;
            if (cur_ff.last) aps_in = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Load each emitted result as pending and move the pending result into the output register
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_id_in    = pend_id_ff;
      pend_err_in   = pend_err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      if ((emit && pend_valid_ff) || fin_move) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = pend_kind_ff;
         rsp_id_in    = pend_id_ff;
         rsp_err_in   = pend_err_ff;
         rsp_last_in  = fin_move;
         rsp_done_in  = fin_move && (cur_ff.last || err_ff != ERR_NONE);
      end
      if (emit) begin
         pend_valid_in = 1'b1;
         pend_kind_in  = emit_kind;
         pend_id_in    = emit_id;
         pend_err_in   = emit_err;
      end else if (fin_move) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         aps_ff        <= 1'b1;
         err_ff        <= ERR_NONE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         aps_ff        <= aps_in;
         err_ff        <= err_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      pend_kind_ff <= pend_kind_in;
      pend_id_ff   <= pend_id_in;
      pend_err_ff  <= pend_err_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_kind      = rsp_kind_ff;
   assign rsp_out_object_id = rsp_id_ff;
   assign rsp_error_code    = rsp_err_ff;
   assign rsp_run_last      = rsp_last_ff;
   assign rsp_expr_done     = rsp_done_ff;

endmodule

@@ hw/rtl/csg_infix_to_rpn.sv @@
// Channel  | Ports                                                   | Direction
// ---------+---------------------------------------------------------+----------
// request  | req_valid/ready, token_kind, object_id, last_token      | in
// response | rsp_valid/ready, out_kind, out_object_id, error_code,   | out
//          | run_last, expr_done                                     |
//
// A token passes through the sequencer states IDLE, START and POP, staying in
// POP for each entry popped ahead of it, and ends in FIN; a skipped token goes
// from START straight to FLUSH or FIN. On the last token FLUSH pops the entries
// one by one until it sees the stack empty, and an error passes through ERR,
// which emits its result. The single stack port takes one push or pop per cycle.
// Synchronous reset empties the stack and the token queue at once.
// A two-entry token queue keeps accepting while the sequencer works, and a
// stalled response holds the sequencer only when it has a result to hand over.
module csg_infix_to_rpn #(
   parameter int STACK_DEPTH = ci2r_pkg::STACK_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ci2r_pkg::KIND_W-1:0]   req_token_kind,
   input  logic [ci2r_pkg::OBJ_W-1:0]    req_object_id,
   input  logic                          req_last_token,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ci2r_pkg::KIND_W-1:0]   rsp_out_kind,
   output logic [ci2r_pkg::OBJ_W-1:0]    rsp_out_object_id,
   output logic [ci2r_pkg::ERR_W-1:0]    rsp_error_code,
   output logic                          rsp_run_last,
   output logic                          rsp_expr_done
);
   import ci2r_pkg::*;

   logic         q_valid, q_ready;
   tok_type      q_tok;
   stk_cmd_type  cmd;
   stk_stat_type stat;

   // Accept and classify tokens
   ci2r_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_token_kind (req_token_kind),
      .req_object_id  (req_object_id),
      .req_last_token (req_last_token),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_tok          (q_tok)
   );

   // Operator stack
   ci2r_stack #(
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   // Run the shunting-yard steps and drive the response
   ci2r_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_ready           (q_ready),
      .q_tok             (q_tok),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_out_object_id (rsp_out_object_id),
      .rsp_error_code    (rsp_error_code),
      .rsp_run_last      (rsp_run_last),
      .rsp_expr_done     (rsp_expr_done)
   );

endmodule
